>>> sv/lsat_pkg.sv
// ----------------------------------------------------------------------------
// lsat_pkg
// Shared types and constants for the set-associative tag lookup with LRU.
// ----------------------------------------------------------------------------
package lsat_pkg;

	localparam int DEF_WAYS     = 4;
	localparam int DEF_SETS     = 64;
	localparam int DEF_TAG_BITS = 20;

	localparam int SET_INDEX_W = 6;
	localparam int TAG_IN_W    = 20;
	localparam int KIND_W      = 2;
	localparam int WAY_OUT_W   = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_HIT      = 2'd0,
		KIND_COLD     = 2'd1,
		KIND_CONFLICT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // write reset value into set state row clr_q
		logic capture;  // latch request, read set rows
		logic update;   // write back set rows, register result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
	} status_t;

endpackage

>>> sv/lsat_ctrl.sv
// ----------------------------------------------------------------------------
// lsat_ctrl
// Sequencer: clearing pass after reset, then capture / update per request.
// ----------------------------------------------------------------------------
module lsat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lsat_pkg::status_t status,
	output lsat_pkg::cmd_t    cmd,
	output logic              busy
);

	lsat_pkg::state_t state_q;
	lsat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsat_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsat_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = lsat_pkg::ST_IDLE;
				end
			end
			lsat_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lsat_pkg::ST_UPDATE;
				end
			end
			lsat_pkg::ST_UPDATE: begin
				state_d = lsat_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsat_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			lsat_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			lsat_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			lsat_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> sv/lsat_dp.sv
// ----------------------------------------------------------------------------
// lsat_dp
// Set state and tag memories, tag compare, way selection and LRU promotion.
// ----------------------------------------------------------------------------
module lsat_dp #(
	parameter int WAYS     = lsat_pkg::DEF_WAYS,
	parameter int SETS     = lsat_pkg::DEF_SETS,
	parameter int TAG_BITS = lsat_pkg::DEF_TAG_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lsat_pkg::cmd_t                     cmd,
	input  logic [lsat_pkg::SET_INDEX_W-1:0]   set_index,
	input  logic [lsat_pkg::TAG_IN_W-1:0]      tag,
	output lsat_pkg::status_t                  status,
	output logic                               done,
	output logic [lsat_pkg::KIND_W-1:0]        access_kind,
	output logic [lsat_pkg::WAY_OUT_W-1:0]     way
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int IDX_N = 2 ** lsat_pkg::SET_INDEX_W;

	typedef logic [WAYS-1:0][WAY_W-1:0]    order_row_t;
	typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

	// memories
	logic [WAYS-1:0] valid_mem [SETS];
	order_row_t      order_mem [SETS];
	tag_row_t        tag_mem   [SETS];

	logic [SET_W-1:0] set_tbl [IDX_N];
	order_row_t       order_init;
	logic [TAG_BITS+lsat_pkg::TAG_IN_W-1:0] tag_ext;

	logic [SET_W-1:0]    clr_q;
	logic [SET_W-1:0]    req_set_q;
	logic [TAG_BITS-1:0] req_tag_q;
	logic [WAYS-1:0]     rd_valid_q;
	order_row_t          rd_order_q;
	tag_row_t            rd_tags_q;

	lsat_pkg::kind_t kind;
	logic [WAY_W-1:0] acc_way;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] pos;
	logic             hit_any;
	logic             free_any;
	logic [WAYS-1:0]  new_valid;
	order_row_t       new_order;
	tag_row_t         new_tags;
	logic [WAY_W+lsat_pkg::WAY_OUT_W-1:0] way_ext;

	lsat_pkg::kind_t                  kind_q;
	logic [lsat_pkg::WAY_OUT_W-1:0]   way_q;
	logic                             done_q;

	// set index reduced modulo SETS, as a constant table
	for (genvar g = 0; g < IDX_N; g++) begin : g_set_tbl
		assign set_tbl[g] = SET_W'(g % SETS);
	end

	for (genvar g = 0; g < WAYS; g++) begin : g_order_init
		assign order_init[g] = WAY_W'(g);
	end

	assign tag_ext = {{TAG_BITS{1'b0}}, tag};

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + SET_W'(1);
		end
	end

	assign status.clear_last = (clr_q == SET_W'(SETS - 1));

	// request capture and registered row read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_set_q  <= set_tbl[set_index];
			req_tag_q  <= tag_ext[TAG_BITS-1:0];
			rd_valid_q <= valid_mem[set_tbl[set_index]];
			rd_order_q <= order_mem[set_tbl[set_index]];
			rd_tags_q  <= tag_mem[set_tbl[set_index]];
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			valid_mem[clr_q] <= '0;
			order_mem[clr_q] <= order_init;
		end else if (cmd.update) begin
			valid_mem[req_set_q] <= new_valid;
			order_mem[req_set_q] <= new_order;
			tag_mem[req_set_q]   <= new_tags;
		end
	end

	// lookup: lowest matching valid way, else lowest invalid way, else LRU
	always_comb begin
		hit_any  = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_valid_q[w] && (rd_tags_q[w] == req_tag_q)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!rd_valid_q[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		if (hit_any) begin
			kind    = lsat_pkg::KIND_HIT;
			acc_way = hit_way;
		end else if (free_any) begin
			kind    = lsat_pkg::KIND_COLD;
			acc_way = free_way;
		end else begin
			kind    = lsat_pkg::KIND_CONFLICT;
			acc_way = rd_order_q[WAYS-1];
		end
	end

	// promote accessed way to the front, shift the ways ahead of it back
	always_comb begin
		pos = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (rd_order_q[i] == acc_way) begin
				pos = WAY_W'(i);
			end
		end
		new_order    = rd_order_q;
		new_order[0] = acc_way;
		for (int i = 1; i < WAYS; i++) begin
			if (WAY_W'(i) <= pos) begin
				new_order[i] = rd_order_q[i-1];
			end
		end
	end

	always_comb begin
		new_valid = rd_valid_q;
		new_tags  = rd_tags_q;
		if (kind != lsat_pkg::KIND_HIT) begin
			new_valid[acc_way] = 1'b1;
			new_tags[acc_way]  = req_tag_q;
		end
	end

	assign way_ext = {{lsat_pkg::WAY_OUT_W{1'b0}}, acc_way};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			kind_q <= kind;
			way_q  <= way_ext[lsat_pkg::WAY_OUT_W-1:0];
		end
	end

	assign done        = done_q;
	assign access_kind = kind_q;
	assign way         = way_q;

endmodule

>>> sv/lru_set_assoc_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// lru_set_assoc_tag_lookup_unit
// Tag lookup and true-LRU replacement for a set-associative cache.
// ----------------------------------------------------------------------------
// A request (set_index, tag) is taken at a rising edge with start high and
// busy low. The result is registered; done is high for one cycle with
// access_kind (hit, cold miss, conflict miss) and the way that was hit or
// filled; the receiver cannot stall, so capture the result in that cycle.
// No new request is taken until the last is written back: the capture step
// reads the set's valid/order row and tag row into registers, the update
// step compares the tags, picks the way, and writes both rows back, so busy
// is high in that step. After reset, busy stays high while a clearing pass
// writes every set's row to all ways invalid, way 0 most recent. The set
// index is reduced modulo SETS, and only the low TAG_BITS bits of tag count.
// ----------------------------------------------------------------------------
module lru_set_assoc_tag_lookup_unit #(
	parameter int WAYS     = lsat_pkg::DEF_WAYS,
	parameter int SETS     = lsat_pkg::DEF_SETS,
	parameter int TAG_BITS = lsat_pkg::DEF_TAG_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lsat_pkg::SET_INDEX_W-1:0] set_index,
	input  logic [lsat_pkg::TAG_IN_W-1:0]    tag,
	output logic                             busy,
	output logic                             done,
	output logic [lsat_pkg::KIND_W-1:0]      access_kind,
	output logic [lsat_pkg::WAY_OUT_W-1:0]   way
);

	// command and status between sequencer and datapath
	lsat_pkg::cmd_t    cmd;
	lsat_pkg::status_t status;

	// sequencer: clear pass, then capture and update for each request
	lsat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: memories, compare, replacement choice, result register
	lsat_dp #(
		.WAYS     (WAYS),
		.SETS     (SETS),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.set_index   (set_index),
		.tag         (tag),
		.status      (status),
		.done        (done),
		.access_kind (access_kind),
		.way         (way)
	);

endmodule

>>> sv/lsat_chk.sv
// ----------------------------------------------------------------------------
// lsat_chk
// Port-level checks for the tag lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module lsat_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [lsat_pkg::KIND_W-1:0]      access_kind
);

	logic accept;
	assign accept = start && !busy;

	// every accepted request yields its result through the request and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("no result two cycles after accepted request");

	// no result without an accepted request before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without request");

	// unit is busy while it updates the set
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted during update");

	// result cycle is free to accept the next request
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result shown");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (access_kind == lsat_pkg::KIND_HIT ||
			access_kind == lsat_pkg::KIND_COLD ||
			access_kind == lsat_pkg::KIND_CONFLICT))
		else $error("illegal access kind");

endmodule

bind lru_set_assoc_tag_lookup_unit lsat_chk u_lsat_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.access_kind (access_kind)
);

>>> tb/lru_set_assoc_tag_lookup_unit_test.sv
// ----------------------------------------------------------------------------
// lru_set_assoc_tag_lookup_unit_test
// Self-checking bench for the set-associative tag lookup with true LRU.
// ----------------------------------------------------------------------------
// A scoreboard model keeps its own valid bits, tags and recency order for
// every set. Each accepted request updates that model, and the predicted
// access kind and way go into a queue. Every done strobe is checked against
// the oldest queued prediction. Directed tests cover cold fills, hits,
// conflict evictions and the set index extremes. A long random phase then
// hammers a few hot sets with small tag pools, so that hits and evictions
// dominate, with random noise requests mixed in.
// ----------------------------------------------------------------------------
module lru_set_assoc_tag_lookup_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_WAYS = lsat_pkg::DEF_WAYS;
	localparam int NUM_SETS = lsat_pkg::DEF_SETS;

	typedef struct {
		lsat_pkg::kind_t                kind;
		logic [lsat_pkg::WAY_OUT_W-1:0] way;
	} access_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             start;
	logic [lsat_pkg::SET_INDEX_W-1:0] set_index;
	logic [lsat_pkg::TAG_IN_W-1:0]    tag;
	logic                             busy;
	logic                             done;
	logic [lsat_pkg::KIND_W-1:0]      access_kind;
	logic [lsat_pkg::WAY_OUT_W-1:0]   way;

	// Scoreboard copy of the cache directory.
	logic [NUM_WAYS-1:0]           line_valid [NUM_SETS];
	logic [lsat_pkg::TAG_IN_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
	logic [1:0]                    mru_order  [NUM_SETS][NUM_WAYS];

	// Predicted results, oldest first.
	access_t pending_access[$];
	int      mismatch_count = 0;

	lru_set_assoc_tag_lookup_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.set_index   (set_index),
		.tag         (tag),
		.busy        (busy),
		.done        (done),
		.access_kind (access_kind),
		.way         (way)
	);

	always #1 clk = ~clk;

	// Put the scoreboard directory in its reset state: all ways invalid,
	// way 0 most recent, the rest in ascending order.
	task automatic clear_directory();
		for (int s = 0; s < NUM_SETS; s++) begin
			line_valid[s] = '0;
			for (int w = 0; w < NUM_WAYS; w++) begin
				line_tag[s][w]  = '0;
				mru_order[s][w] = w[1:0];
			end
		end
	endtask

	// Look the tag up in the set, fill or evict on a miss, and make the
	// accessed way most recently used. Returns the access the block must report.
	function automatic access_t lookup_and_update(
			input logic [lsat_pkg::SET_INDEX_W-1:0] s,
			input logic [lsat_pkg::TAG_IN_W-1:0] t);
		access_t res;
		bit      found;
		int      pos;
		found    = 1'b0;
		pos      = 0;
		res.kind = lsat_pkg::KIND_CONFLICT;
		res.way  = '0;
		// A valid matching way anywhere in the set is a hit.
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!found && line_valid[s][w] && line_tag[s][w] == t) begin
				res.kind = lsat_pkg::KIND_HIT;
				res.way  = w[1:0];
				found    = 1'b1;
			end
		end
		// Otherwise take the lowest invalid way.
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!found && !line_valid[s][w]) begin
				res.kind = lsat_pkg::KIND_COLD;
				res.way  = w[1:0];
				found    = 1'b1;
			end
		end
		// Set full: evict the least recently used way.
		if (!found)
			res.way = mru_order[s][NUM_WAYS-1];
		if (res.kind != lsat_pkg::KIND_HIT) begin
			line_valid[s][res.way] = 1'b1;
			line_tag[s][res.way]   = t;
		end
		// Promote the accessed way; the others keep their relative order.
		for (int i = 0; i < NUM_WAYS; i++)
			if (mru_order[s][i] == res.way)
				pos = i;
		for (int i = pos; i > 0; i--)
			mru_order[s][i] = mru_order[s][i-1];
		mru_order[s][0] = res.way;
		return res;
	endfunction

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Drive one request after an idle gap and hold it until the block takes it.
	// Start stays high across back-to-back requests; it is dropped only in gaps and while draining.
	task automatic send_request(input logic [lsat_pkg::SET_INDEX_W-1:0] s,
			input logic [lsat_pkg::TAG_IN_W-1:0] t, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start     <= 1'b1;
		set_index <= s;
		tag       <= t;
		// Hold the request until an edge sees busy low.
		forever begin
			@(posedge clk);
			if (busy === 1'b0)
				break;
		end
		pending_access.push_back(lookup_and_update(s, t));
	endtask

	// Drop start and wait until every predicted result has come back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_access.size() != 0)
			@(posedge clk);
	endtask

	// Checker: every done strobe must match the oldest prediction.
	always @(posedge clk) begin
		access_t exp_acc;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_access.size() == 0) begin
				$error("done strobe with no request outstanding");
				mismatch_count++;
			end else begin
				exp_acc = pending_access.pop_front();
				if (access_kind !== exp_acc.kind) begin
					$error("access_kind: expected %0d, actual %0d", exp_acc.kind,
						access_kind);
					mismatch_count++;
				end
				if (way !== exp_acc.way) begin
					$error("way: expected %0d, actual %0d", exp_acc.way, way);
					mismatch_count++;
				end
			end
		end
	end

	// Fill all four ways of set 0 with tags that toggle every tag bit.
	task automatic test_cold_fill();
		send_request(6'd0, 20'h00000, 0);
		send_request(6'd0, 20'hFFFFF, 0);
		send_request(6'd0, 20'hAAAAA, 1);
		send_request(6'd0, 20'h55555, 0);
	endtask

	// Hit resident tags out of order to shuffle the recency order.
	task automatic test_hits();
		send_request(6'd0, 20'h55555, 0);
		send_request(6'd0, 20'h00000, 2);
		send_request(6'd0, 20'hFFFFF, 0);
	endtask

	// Miss on a full set: evict the least recently used way, twice, then hit
	// the first of the two lines brought in.
	task automatic test_conflict_evict();
		send_request(6'd0, 20'h12345, 0);
		send_request(6'd0, 20'h0F0F0, 0);
		send_request(6'd0, 20'h12345, 3);
	endtask

	// Top set and sets with alternating index bits; tags already used in set 0
	// must miss here since the sets are independent.
	task automatic test_set_extremes();
		send_request(6'd63, 20'h00000, 0);
		send_request(6'd63, 20'hFFFFF, 0);
		send_request(6'd63, 20'h00000, 0);
		send_request(6'd42, 20'h12345, 1);
		send_request(6'd21, 20'h12345, 0);
	endtask

	// Let the pipeline empty completely before carrying on.
	task automatic test_drain_pause();
		drain_results();
		send_request(6'd0, 20'h0F0F0, 0);
		send_request(6'd63, 20'hFFFFF, 0);
		drain_results();
	endtask

	// Random traffic in phases. Each phase picks a few hot sets and a small
	// tag pool, so the sets fill up and hits and evictions dominate; the rest
	// is noise on random sets with random tags.
	task automatic test_random_mix(input int num_requests);
		logic [lsat_pkg::SET_INDEX_W-1:0] hot_set [4];
		logic [lsat_pkg::TAG_IN_W-1:0]    tag_pool [8];
		int                               pool_size;
		bit                               burst;
		int                               sent;
		int                               phase_len;
		sent = 0;
		while (sent < num_requests) begin
			for (int i = 0; i < 4; i++)
				hot_set[i] = lsat_pkg::SET_INDEX_W'($urandom_range(0, NUM_SETS - 1));
			for (int i = 0; i < 8; i++)
				tag_pool[i] = lsat_pkg::TAG_IN_W'($urandom);
			pool_size = $urandom_range(2, 8);
			burst     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 150);
			for (int n = 0; n < phase_len && sent < num_requests; n++) begin
				if ($urandom_range(0, 99) < 85)
					send_request(hot_set[$urandom_range(0, 3)],
						tag_pool[$urandom_range(0, pool_size - 1)],
						burst ? 0 : pick_gap());
				else
					send_request(lsat_pkg::SET_INDEX_W'($urandom),
						lsat_pkg::TAG_IN_W'($urandom),
						burst ? 0 : pick_gap());
				sent++;
			end
			// Now and then let everything drain between phases.
			if ($urandom_range(0, 4) == 0)
				drain_results();
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n    = 1'b0;
		start     = 1'b0;
		set_index = '0;
		tag       = '0;
		clear_directory();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The block runs a clearing pass after reset; send_request waits on
		// busy, so no extra delay is needed here.
		test_cold_fill();
		test_hits();
		test_conflict_evict();
		test_set_extremes();
		test_drain_pause();
		test_random_mix(1950);

		@(negedge clk);
		start <= 1'b0;
		wait_cycles = 0;
		while (pending_access.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		// Then keep watching for stray strobes.
		repeat (8) @(posedge clk);
		if (pending_access.size() != 0) begin
			$error("%0d predicted results never arrived", pending_access.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
sv/lsat_pkg.sv
sv/lsat_ctrl.sv
sv/lsat_dp.sv
sv/lru_set_assoc_tag_lookup_unit.sv
sv/lsat_chk.sv
tb/lru_set_assoc_tag_lookup_unit_test.sv
